FILE: rtl/core/pal_pkg.sv
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = 7;
  localparam int DW       = 32;
  localparam int OPW      = 3;
  localparam int SW       = 2;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [OPW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } pal_op_e;

  typedef enum logic [SW-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } pal_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_PUT,
    S_SCAN,
    S_FINISH
  } pal_state_e;

  typedef struct packed {
    logic        accept;
    logic        start_ins;
    logic        start_scan;
    logic        step;
    logic        put;
    logic        shrink;
    logic        clear;
    logic        set_status;
    pal_status_e status_val;
    logic        emit;
  } pal_ctl_t;

  typedef struct packed {
    logic [OPW-1:0] op;
    logic           pos_ok;
    logic           full;
    logic           rd_go;
    logic           pend;
    logic           hit;
    logic           out_free;
  } pal_stat_t;

endpackage

FILE: rtl/core/pal_ctrl.sv
module pal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pal_pkg::pal_stat_t stat_i,
  output pal_pkg::pal_ctl_t  ctl_o
);
  import pal_pkg::*;

  pal_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.pos_ok && !stat_i.full) state_d = S_SHIFT_UP;
            else state_d = S_FINISH;
          end
          OP_REMOVE, OP_READ: begin
            if (stat_i.pos_ok) state_d = S_SCAN;
            else state_d = S_FINISH;
          end
          OP_LOCATE: state_d = S_SCAN;
          default:   state_d = S_FINISH;
        endcase
      end
      S_SHIFT_UP: begin
        if (!stat_i.rd_go && !stat_i.pend) state_d = S_PUT;
      end
      S_PUT: state_d = S_FINISH;
      S_SCAN: begin
        if (stat_i.hit || (!stat_i.rd_go && !stat_i.pend)) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.accept = in_valid_i;
      end
      S_CHECK: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (!stat_i.pos_ok) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_BADPOS;
            end else if (stat_i.full) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_FULL;
            end else begin
              ctl_o.start_ins = 1'b1;
            end
          end
          OP_REMOVE, OP_READ: begin
            if (!stat_i.pos_ok) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_BADPOS;
            end else begin
              ctl_o.start_scan = 1'b1;
            end
          end
          OP_LOCATE: begin
            ctl_o.start_scan = 1'b1;
            ctl_o.set_status = 1'b1;
            ctl_o.status_val = ST_NOTFOUND;
          end
          OP_CLEAR: ctl_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_SHIFT_UP: ctl_o.step = 1'b1;
      S_PUT:      ctl_o.put = 1'b1;
      S_SCAN: begin
        ctl_o.step = 1'b1;
        if (!stat_i.hit && !stat_i.rd_go && !stat_i.pend && (stat_i.op == OP_REMOVE)) begin
          ctl_o.shrink = 1'b1;
        end
      end
      S_FINISH: ctl_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/pal_dp.sv
module pal_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pal_pkg::OPW-1:0]           cmd_i,
  input  logic [pal_pkg::CW-1:0]            position_i,
  input  logic signed [pal_pkg::DW-1:0]     value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pal_pkg::SW-1:0]            status_o,
  output logic signed [pal_pkg::DW-1:0]     data_out_o,
  output logic [pal_pkg::CW-1:0]            found_position_o,
  output logic [pal_pkg::CW-1:0]            item_count_o,
  input  pal_pkg::pal_ctl_t                 ctl_i,
  output pal_pkg::pal_stat_t                stat_o
);
  import pal_pkg::*;

  logic [DW-1:0] store_q [CAPACITY];

  logic [OPW-1:0] op_q;
  logic [CW-1:0]  pos_q;
  logic [DW-1:0]  val_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  pa_q, pa_d;
  logic           pv_q, pv_d;
  logic [DW-1:0]  rdata_q;
  logic [DW-1:0]  data_q;
  logic [CW-1:0]  found_q;
  pal_status_e    status_q;
  logic           out_valid_q;
  logic [SW-1:0]  out_status_q;
  logic [DW-1:0]  out_data_q;
  logic [CW-1:0]  out_found_q;
  logic [CW-1:0]  out_count_q;

  logic           is_ins, is_rem, is_read, is_loc;
  logic [CW-1:0]  pos_m1;
  logic [CW-1:0]  scan_end;
  logic           rd_go;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [DW-1:0]  wr_data;
  logic           first_rd;
  logic           hit;
  logic           out_free;

  assign is_ins   = (op_q == OP_INSERT);
  assign is_rem   = (op_q == OP_REMOVE);
  assign is_read  = (op_q == OP_READ);
  assign is_loc   = (op_q == OP_LOCATE);
  assign pos_m1   = pos_q - 1'b1;
  assign scan_end = is_read ? pos_q : cnt_q;
  assign rd_go    = is_ins ? (idx_q >= pos_q) : (idx_q < scan_end);
  assign rd_en    = ctl_i.step && rd_go;
  assign rd_addr  = is_ins ? AW'(idx_q - 1'b1) : AW'(idx_q);
  assign first_rd = (pa_q == pos_m1);
  assign hit      = pv_q && is_loc && (rdata_q == val_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(pos_m1);
    wr_data = rdata_q;
    if (ctl_i.put) begin
      wr_en   = 1'b1;
      wr_data = val_q;
    end else if (ctl_i.step && pv_q) begin
      if (is_ins) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pa_q);
      end else if (is_rem && !first_rd) begin
        wr_en   = 1'b1;
        wr_addr = AW'(pa_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= store_q[rd_addr];
  end

  always_comb begin
    idx_d = idx_q;
    pa_d  = pa_q;
    pv_d  = pv_q;
    cnt_d = cnt_q;
    if (ctl_i.start_ins) begin
      idx_d = cnt_q;
      pv_d  = 1'b0;
    end else if (ctl_i.start_scan) begin
      idx_d = is_loc ? '0 : pos_m1;
      pv_d  = 1'b0;
    end else if (ctl_i.step) begin
      pv_d = rd_go;
      if (rd_go) begin
        pa_d  = idx_q;
        idx_d = is_ins ? idx_q - 1'b1 : idx_q + 1'b1;
      end
    end
    if (ctl_i.put) cnt_d = cnt_q + 1'b1;
    else if (ctl_i.shrink) cnt_d = cnt_q - 1'b1;
    else if (ctl_i.clear) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pv_q  <= pv_d;
      if (ctl_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pa_q  <= pa_d;
    if (ctl_i.accept) begin
      op_q     <= cmd_i;
      pos_q    <= position_i;
      val_q    <= value_i;
      status_q <= ST_OK;
      data_q   <= '0;
      found_q  <= '0;
    end else begin
      if (ctl_i.set_status) status_q <= ctl_i.status_val;
      if (ctl_i.step && pv_q) begin
        if (is_read || (is_rem && first_rd)) data_q <= rdata_q;
        if (hit) begin
          found_q  <= pa_q + 1'b1;
          status_q <= ST_OK;
        end
      end
    end
    if (ctl_i.emit) begin
      out_status_q <= status_q;
      out_data_q   <= data_q;
      out_found_q  <= found_q;
      out_count_q  <= cnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign data_out_o       = out_data_q;
  assign found_position_o = out_found_q;
  assign item_count_o     = out_count_q;

  always_comb begin
    stat_o          = '0;
    stat_o.op       = op_q;
    stat_o.pos_ok   = is_ins ? ((pos_q != '0) && ({1'b0, pos_q} <= ({1'b0, cnt_q} + 1'b1)))
                             : ((pos_q != '0) && (pos_q <= cnt_q));
    stat_o.full     = (cnt_q >= CAP_CNT);
    stat_o.rd_go    = rd_go;
    stat_o.pend     = pv_q;
    stat_o.hit      = hit;
    stat_o.out_free = out_free;
  end

endmodule

FILE: rtl/core/positional_array_list_unit.sv
// Channel   | Direction | Handshake                 | Payload
// request   | in        | in_valid_i / in_stall_o   | cmd_i, position_i, value_i
// result    | out       | out_valid_o / out_stall_i | status_o, data_out_o,
//           |           |                           | found_position_o, item_count_o
//
// One request at a time: in_stall_o stays high from acceptance until the result
// enters the output register. Insert and remove take longer the more entries
// shift, and locate the further along the list the match lies, if any.
// Every shift or compare step reads one entry of the store and writes at most one.
// Reset clears the count and the result valid flag; the store needs no clearing.
// A stalled result sits in the output register while the next request is taken.
module positional_array_list_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pal_pkg::OPW-1:0]       cmd_i,
  input  logic [pal_pkg::CW-1:0]        position_i,
  input  logic signed [pal_pkg::DW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pal_pkg::SW-1:0]        status_o,
  output logic signed [pal_pkg::DW-1:0] data_out_o,
  output logic [pal_pkg::CW-1:0]        found_position_o,
  output logic [pal_pkg::CW-1:0]        item_count_o
);
  import pal_pkg::*;

  pal_ctl_t  ctl;
  pal_stat_t stat;

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  pal_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .data_out_o       (data_out_o),
    .found_position_o (found_position_o),
    .item_count_o     (item_count_o),
    .ctl_i            (ctl),
    .stat_o           (stat)
  );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_REQUESTS = 1880;
  localparam int PHASE_LEN       = 160;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [OPW-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OPW-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] VAL_NEG = 32'shFFFF_FFFF;

  typedef enum int {
    PH_GROW,
    PH_HOVER,
    PH_SHRINK,
    PH_MIXED
  } list_phase_e;

  typedef struct packed {
    pal_status_e           status;
    logic signed [DW-1:0]  data;
    logic [CW-1:0]         found;
    logic [CW-1:0]         count;
  } list_result_t;

  typedef struct packed {
    logic [OPW-1:0]        op;
    logic [CW-1:0]         pos;
    logic signed [DW-1:0]  val;
    logic                  typed;
    list_result_t          res;
  } directed_row_t;

  localparam directed_row_t DIRECTED [26] = '{
    '{OP_READ,     7'd1,   32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd0}},
    '{OP_REMOVE,   7'd0,   32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd0}},
    '{OP_LOCATE,   7'd0,   32'sh0,    1'b1, '{ST_NOTFOUND, 32'sh0,  7'd0, 7'd0}},
    '{OP_INSERT,   7'd2,   32'sh5,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd0}},
    '{OP_INSERT,   7'd0,   32'sh5,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd0}},
    '{OP_INSERT,   7'd1,   VAL_MAX,   1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd1}},
    '{OP_INSERT,   7'd2,   VAL_MIN,   1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd2}},
    '{OP_INSERT,   7'd1,   VAL_NEG,   1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd3}},
    '{OP_INSERT,   7'd5,   32'sh1,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd3}},
    '{OP_READ,     7'd1,   32'sh0,    1'b1, '{ST_OK,       VAL_NEG, 7'd0, 7'd3}},
    '{OP_READ,     7'd3,   32'sh0,    1'b1, '{ST_OK,       VAL_MIN, 7'd0, 7'd3}},
    '{OP_READ,     7'd4,   32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd3}},
    '{OP_READ,     7'd127, 32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd3}},
    '{OP_LOCATE,   7'd0,   VAL_MIN,   1'b1, '{ST_OK,       32'sh0,  7'd3, 7'd3}},
    '{OP_LOCATE,   7'd127, VAL_MAX,   1'b1, '{ST_OK,       32'sh0,  7'd2, 7'd3}},
    '{OP_LOCATE,   7'd1,   32'sh0,    1'b1, '{ST_NOTFOUND, 32'sh0,  7'd0, 7'd3}},
    '{OP_INSERT,   7'd4,   VAL_MAX,   1'b0, '{ST_OK,       32'sh0,  7'd0, 7'd0}},
    '{OP_LOCATE,   7'd0,   VAL_MAX,   1'b1, '{ST_OK,       32'sh0,  7'd2, 7'd4}},
    '{OP_REMOVE,   7'd2,   32'sh0,    1'b1, '{ST_OK,       VAL_MAX, 7'd0, 7'd3}},
    '{OP_REMOVE,   7'd4,   32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd3}},
    '{OP_REMOVE,   7'd3,   32'sh0,    1'b1, '{ST_OK,       VAL_MAX, 7'd0, 7'd2}},
    '{OP_UNDEF_LO, 7'd64,  32'sh7B,   1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd2}},
    '{OP_UNDEF_HI, 7'd127, VAL_NEG,   1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd2}},
    '{OP_CLEAR,    7'd127, 32'sh55AA, 1'b1, '{ST_OK,       32'sh0,  7'd0, 7'd0}},
    '{OP_READ,     7'd1,   32'sh0,    1'b1, '{ST_BADPOS,   32'sh0,  7'd0, 7'd0}},
    '{OP_INSERT,   7'd1,   32'sh0,    1'b0, '{ST_OK,       32'sh0,  7'd0, 7'd0}}
  };

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [OPW-1:0]       cmd_i        = '0;
  logic [CW-1:0]        position_i   = '0;
  logic signed [DW-1:0] value_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [SW-1:0]        status_o;
  logic signed [DW-1:0] data_out_o;
  logic [CW-1:0]        found_position_o;
  logic [CW-1:0]        item_count_o;

  logic signed [DW-1:0] list_mem [CAPACITY];
  int                   list_len     = 0;
  list_result_t         pending_results [$];
  int                   mismatch_count = 0;
  int                   idle_cycles  = 0;
  int                   stall_left   = 0;
  bit                   idle_on      = 1'b1;

  positional_array_list_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .data_out_o       (data_out_o),
    .found_position_o (found_position_o),
    .item_count_o     (item_count_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic list_result_t apply_request(input logic [OPW-1:0] op,
                                                 input logic [CW-1:0] pos,
                                                 input logic signed [DW-1:0] val);
    list_result_t r;
    int           p;
    r        = '0;
    r.status = ST_OK;
    p        = int'(pos);
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = list_mem[p-1];
          for (int k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      OP_READ: begin
        if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else r.data = list_mem[p-1];
      end
      OP_LOCATE: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < list_len && r.status == ST_NOTFOUND; k++) begin
          if (list_mem[k] == val) begin
            r.found  = CW'(k + 1);
            r.status = ST_OK;
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = CW'(list_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OPW-1:0] pick_op(input list_phase_e phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OPW'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    if (r < 4 && (phase == PH_SHRINK || phase == PH_MIXED)) return OP_CLEAR;
    case (phase)
      PH_GROW:   return r < 78 ? OP_INSERT : r < 85 ? OP_REMOVE : r < 92 ? OP_READ : OP_LOCATE;
      PH_HOVER:  return r < 55 ? OP_INSERT : r < 72 ? OP_REMOVE : r < 85 ? OP_READ : OP_LOCATE;
      PH_SHRINK: return r < 18 ? OP_INSERT : r < 68 ? OP_REMOVE : r < 84 ? OP_READ : OP_LOCATE;
      default:   return r < 35 ? OP_INSERT : r < 60 ? OP_REMOVE : r < 80 ? OP_READ : OP_LOCATE;
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_position(input logic [OPW-1:0] op);
    int r;
    int top;
    r   = $urandom_range(0, 99);
    top = (op == OP_INSERT) ? list_len + 1 : list_len;
    if (top < 1) top = 1;
    if (r < 6) return '0;
    if (r < 12) return CW'($urandom_range(0, 127));
    if (r < 18) return CW'(top + 1);
    if (r < 28) return CW'(top);
    return CW'($urandom_range(1, top));
  endfunction

  function automatic logic signed [DW-1:0] pick_value(input bit for_locate);
    int r;
    r = $urandom_range(0, 99);
    if (for_locate && list_len > 0 && r < 60) return list_mem[$urandom_range(0, list_len - 1)];
    r = $urandom_range(0, 99);
    if (r < 3) return VAL_MAX;
    if (r < 6) return VAL_MIN;
    if (r < 9) return VAL_NEG;
    if (r < 12) return '0;
    if (r < 45) return DW'($urandom_range(0, 15));
    return $urandom;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [OPW-1:0] op, input logic [CW-1:0] pos,
                              input logic signed [DW-1:0] val, input logic typed,
                              input list_result_t typed_res);
    int           gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(op, pos, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= stall_left > 0;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none pending: status %0d data %0d found %0d count %0d",
                                status_o, data_out_o, found_position_o, item_count_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status || data_out_o !== exp_res.data ||
            found_position_o !== exp_res.found || item_count_o !== exp_res.count) begin
          note_mismatch($sformatf(
            "expected status %0d data %0d found %0d count %0d, got %0d %0d %0d %0d",
            exp_res.status, exp_res.data, exp_res.found, exp_res.count,
            status_o, data_out_o, found_position_o, item_count_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    list_phase_e    phase;
    logic [OPW-1:0] op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].val,
                   DIRECTED[i].typed, DIRECTED[i].res);
    end
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      phase   = list_phase_e'((n / PHASE_LEN) % 4);
      idle_on = ((n / PHASE_LEN) % 3) != 2;
      op      = pick_op(phase);
      send_request(op, pick_position(op), pick_value(op == OP_LOCATE), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
